// ===== rtl/fpisl_pkg.sv =====
// Shared types, constants and small constant functions for the four-point light sensor pipeline.
// Depends on nothing; used by every module under rtl.
package fpisl_pkg;

    // Pipeline depths of the three datapath units.
    localparam int SINE_STEPS = 5;
    localparam int SINE_LAT   = 2 + 3 * SINE_STEPS + 1;
    localparam int ROT_LAT    = 4;
    localparam int RECIP_LAT  = 5 + 32;

    // Width of a sensor point coordinate in raw units.
    localparam int POINT_W = 35;

    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

    // Configuration register indexes.
    localparam logic [1:0] REG_OFFSET_FORWARD = 2'd0;
    localparam logic [1:0] REG_OFFSET_SIDE    = 2'd1;

    typedef struct packed {
        logic signed [POINT_W-1:0] x;
        logic signed [POINT_W-1:0] y;
    } point_t;

    // Divisors of the Taylor series steps, in evaluation order.
    function automatic logic [6:0] sine_div(input int step);
        logic [6:0] d;
        unique case (step)
            0:       d = 7'd110;
            1:       d = 7'd72;
            2:       d = 7'd42;
            3:       d = 7'd20;
            default: d = 7'd6;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor); the quotient estimate is then at most one short.
    function automatic logic [29:0] sine_recip(input int step);
        logic [29:0] m;
        unique case (step)
            0:       m = 30'd39045157;
            1:       m = 30'd59652323;
            2:       m = 30'd102261126;
            3:       m = 30'd214748364;
            default: m = 30'd715827882;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/fpisl_qsine.sv =====
// Pipelined quarter-wave sine in Q30: a Taylor series evaluated as five nested steps.
// Depends on fpisl_pkg for the step divisors and their reciprocals.
module fpisl_qsine
(
    input  logic        clk,
    input  logic        advance,
    input  logic [30:0] angle,
    output logic [30:0] sine
);

    logic [61:0] zp;
    logic [61:0] zz;
    logic [61:0] ft;
    logic [30:0] z1_reg;
    logic [30:0] z0_reg;
    logic [31:0] z20_reg;
    logic [30:0] sine_reg;

    logic [30:0] z_s  [0:fpisl_pkg::SINE_STEPS-1];
    logic [31:0] z2_s [0:fpisl_pkg::SINE_STEPS-1];
    logic [30:0] t_s  [0:fpisl_pkg::SINE_STEPS-1];

    assign zp = angle * fpisl_pkg::HALF_PI_Q30;
    assign zz = z1_reg * z1_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            z1_reg  <= zp[60:30];
            z0_reg  <= z1_reg;
            z20_reg <= zz[61:30];
        end
    end

    for (genvar i = 0; i < fpisl_pkg::SINE_STEPS; i++)
    begin : g_step
        logic [30:0] z_in;
        logic [31:0] z2_in;
        logic [30:0] t_in;
        logic [62:0] pa;
        logic [61:0] pm;
        logic [31:0] rem;
        logic [30:0] q;
        logic [31:0] p_reg;
        logic [31:0] pb_reg;
        logic [29:0] qe_reg;
        logic [30:0] za_reg;
        logic [30:0] zb_reg;
        logic [31:0] z2a_reg;
        logic [31:0] z2b_reg;

        if (i == 0)
        begin : g_first
            assign z_in  = z0_reg;
            assign z2_in = z20_reg;
            assign t_in  = fpisl_pkg::ONE_Q30;
        end
        else
        begin : g_next
            assign z_in  = z_s[i-1];
            assign z2_in = z2_s[i-1];
            assign t_in  = t_s[i-1];
        end

        assign pa  = z2_in * t_in;
        assign pm  = p_reg * fpisl_pkg::sine_recip(i);
        assign rem = pb_reg - 32'(qe_reg * fpisl_pkg::sine_div(i));
        assign q   = {1'b0, qe_reg} + {30'd0, (rem >= {25'd0, fpisl_pkg::sine_div(i)})};

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                p_reg   <= pa[61:30];
                za_reg  <= z_in;
                z2a_reg <= z2_in;
                qe_reg  <= pm[61:32];
                pb_reg  <= p_reg;
                zb_reg  <= za_reg;
                z2b_reg <= z2a_reg;
                t_s[i]  <= fpisl_pkg::ONE_Q30 - q;
                z_s[i]  <= zb_reg;
                z2_s[i] <= z2b_reg;
            end
        end
    end

    assign ft = z_s[fpisl_pkg::SINE_STEPS-1] * t_s[fpisl_pkg::SINE_STEPS-1];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sine_reg <= ft[60:30];
        end
    end

    assign sine = sine_reg;

endmodule

// ===== rtl/fpisl_rotate.sv =====
// Quadrant mapping, rotation of the four sensor offsets and addition of the pose.
// Depends on fpisl_pkg for the sensor point type.
module fpisl_rotate
(
    input  logic                       clk,
    input  logic                       advance,
    input  logic [30:0]                sin_q,
    input  logic [30:0]                cos_q,
    input  logic [1:0]                 quadrant,
    input  logic signed [31:0]         x,
    input  logic signed [31:0]         y,
    input  logic [30:0]                fwd,
    input  logic [30:0]                side,
    output fpisl_pkg::point_t [3:0]    points
);

    logic signed [31:0] sp;
    logic signed [31:0] cp;
    logic signed [31:0] sn_next;
    logic signed [31:0] cs_next;
    logic signed [31:0] sn_reg;
    logic signed [31:0] cs_reg;
    logic signed [31:0] x1_reg, x2_reg, x3_reg;
    logic signed [31:0] y1_reg, y2_reg, y3_reg;
    logic signed [63:0] fc_reg, ss_reg, fs_reg, sc_reg;
    logic signed [63:0] a_reg, b_reg, c_reg, e_reg;
    fpisl_pkg::point_t [3:0] points_next;
    fpisl_pkg::point_t [3:0] points_reg;

    // Round to nearest with halves upward: add one half, then floor.
    function automatic logic signed [fpisl_pkg::POINT_W-1:0] place(
        input logic signed [31:0] base,
        input logic signed [63:0] v
    );
        logic signed [63:0] w;
        logic signed [33:0] r;
        w = v + 64'sd536870912;
        r = w[63:30];
        return $signed({{3{base[31]}}, base}) + $signed({r[33], r});
    endfunction

    assign sp = $signed({1'b0, sin_q});
    assign cp = $signed({1'b0, cos_q});

    always_comb
    begin
        unique case (quadrant)
            2'd0:
            begin
                sn_next = sp;
                cs_next = cp;
            end
            2'd1:
            begin
                sn_next = cp;
                cs_next = -sp;
            end
            2'd2:
            begin
                sn_next = -sp;
                cs_next = -cp;
            end
            default:
            begin
                sn_next = -cp;
                cs_next = sp;
            end
        endcase
    end

    // Front-left takes (+f,+s), front-right (+f,-s); the rear ones are the negations.
    always_comb
    begin
        points_next[0].x = place(x3_reg, a_reg);
        points_next[0].y = place(y3_reg, c_reg);
        points_next[1].x = place(x3_reg, b_reg);
        points_next[1].y = place(y3_reg, e_reg);
        points_next[2].x = place(x3_reg, -b_reg);
        points_next[2].y = place(y3_reg, -e_reg);
        points_next[3].x = place(x3_reg, -a_reg);
        points_next[3].y = place(y3_reg, -c_reg);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sn_reg     <= sn_next;
            cs_reg     <= cs_next;
            x1_reg     <= x;
            y1_reg     <= y;
            fc_reg     <= $signed({1'b0, fwd}) * cs_reg;
            ss_reg     <= $signed({1'b0, side}) * sn_reg;
            fs_reg     <= $signed({1'b0, fwd}) * sn_reg;
            sc_reg     <= $signed({1'b0, side}) * cs_reg;
            x2_reg     <= x1_reg;
            y2_reg     <= y1_reg;
            a_reg      <= fc_reg - ss_reg;
            b_reg      <= fc_reg + ss_reg;
            c_reg      <= fs_reg + sc_reg;
            e_reg      <= fs_reg - sc_reg;
            x3_reg     <= x2_reg;
            y3_reg     <= y2_reg;
            points_reg <= points_next;
        end
    end

    assign points = points_reg;

endmodule

// ===== rtl/fpisl_recip.sv =====
// Squared distance of one sensor point and its pipelined restoring reciprocal, one bit a stage.
// Depends on fpisl_pkg for the sensor point type.
module fpisl_recip
#(
    parameter int COORD_FRAC_BITS = 16
)
(
    input  logic              clk,
    input  logic              advance,
    input  fpisl_pkg::point_t point,
    output logic [31:0]       level,
    output logic              saturated
);

    localparam int E  = 3 * COORD_FRAC_BITS;
    localparam int NW = E + 1;
    localparam int DW = 67;
    localparam int CW = DW + 32;
    localparam logic [CW-1:0] N0 = CW'(1) << E;

    logic [34:0] axf;
    logic [34:0] ayf;
    logic [32:0] ax_reg, ay_reg;
    logic [31:0] hhx_reg, hhy_reg;
    logic [32:0] hlx_reg, hly_reg;
    logic [33:0] llx_reg, lly_reg;
    logic [65:0] sqx_reg, sqy_reg;
    logic [DW-1:0] d_reg;
    logic [DW-1:0] d0_reg;
    logic          sat0_reg;

    logic [NW-1:0] n_s   [0:31];
    logic [31:0]   q_s   [0:31];
    logic [DW-1:0] d_s   [0:31];
    logic          sat_s [0:31];

    assign axf = point.x[fpisl_pkg::POINT_W-1] ? -point.x : point.x;
    assign ayf = point.y[fpisl_pkg::POINT_W-1] ? -point.y : point.y;

    // Each square is split into 16 and 17 bit halves.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ax_reg   <= axf[32:0];
            ay_reg   <= ayf[32:0];
            hhx_reg  <= ax_reg[32:17] * ax_reg[32:17];
            hlx_reg  <= ax_reg[32:17] * ax_reg[16:0];
            llx_reg  <= ax_reg[16:0] * ax_reg[16:0];
            hhy_reg  <= ay_reg[32:17] * ay_reg[32:17];
            hly_reg  <= ay_reg[32:17] * ay_reg[16:0];
            lly_reg  <= ay_reg[16:0] * ay_reg[16:0];
            sqx_reg  <= {hhx_reg, 34'd0} + {15'd0, hlx_reg, 18'd0} + {32'd0, llx_reg};
            sqy_reg  <= {hhy_reg, 34'd0} + {15'd0, hly_reg, 18'd0} + {32'd0, lly_reg};
            d_reg    <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
            d0_reg   <= d_reg;
            sat0_reg <= ({d_reg, 32'd0} <= N0);
        end
    end

    for (genvar j = 0; j < 32; j++)
    begin : g_bit
        logic [NW-1:0] n_in;
        logic [31:0]   q_in;
        logic [DW-1:0] d_in;
        logic          sat_in;
        logic [CW-1:0] t;
        logic [CW-1:0] nx;
        logic [CW-1:0] diff;
        logic          ge;

        if (j == 0)
        begin : g_first
            assign n_in   = N0[NW-1:0];
            assign q_in   = '0;
            assign d_in   = d0_reg;
            assign sat_in = sat0_reg;
        end
        else
        begin : g_next
            assign n_in   = n_s[j-1];
            assign q_in   = q_s[j-1];
            assign d_in   = d_s[j-1];
            assign sat_in = sat_s[j-1];
        end

        assign t    = {32'd0, d_in} << (31 - j);
        assign nx   = {{(CW-NW){1'b0}}, n_in};
        assign ge   = (nx >= t);
        assign diff = nx - t;

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                n_s[j]   <= ge ? diff[NW-1:0] : n_in;
                q_s[j]   <= q_in | ({31'd0, ge} << (31 - j));
                d_s[j]   <= d_in;
                sat_s[j] <= sat_in;
            end
        end
    end

    assign level     = sat_s[31] ? 32'hFFFF_FFFF : q_s[31];
    assign saturated = sat_s[31];

endmodule

// ===== rtl/four_point_inverse_square_light.sv =====
// Top level of the four-point inverse-square light sensor pipeline.
// Depends on fpisl_pkg, fpisl_qsine, fpisl_rotate and fpisl_recip.
//
// This block takes one robot pose per transaction (pos_x and pos_y in signed fixed point with
// COORD_FRAC_BITS fraction bits, heading as a binary angle of which the low ANGLE_BITS bits
// count) and returns, in order, one result transaction per pose: the inverse-square light
// level at each of four sensors placed at (+/-offset_forward, +/-offset_side) in the body
// frame, with a light source of unit strength at the origin. A level that would not fit 32
// bits, a sensor sitting on the source included, reads as all ones and sets that sensor's
// bit in saturated_flags (bit 0 front-left, bit 1 front-right, bit 2 rear-left, bit 3
// rear-right). The datapath is a fully pipelined chain that takes a new pose in every clock
// cycle unless a waiting result is stalled; an accepted pose passes in turn through the
// sine/cosine units, the rotation, the squared distance and saturation test, the restoring
// reciprocal and the output register. The whole chain holds still while a waiting result
// is stalled, so nothing is lost or repeated. The two offsets are written through the plain
// write port and must only be changed while no transaction is in flight.
module four_point_inverse_square_light
#(
    parameter int COORD_FRAC_BITS = 16,
    parameter int ANGLE_BITS      = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic [15:0]        heading,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        front_left_level,
    output logic [31:0]        front_right_level,
    output logic [31:0]        rear_left_level,
    output logic [31:0]        rear_right_level,
    output logic [3:0]         saturated_flags,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [30:0]        cfg_data
);

    localparam int SINE_LAT  = fpisl_pkg::SINE_LAT;
    localparam int PIPE_LAT  = fpisl_pkg::SINE_LAT + fpisl_pkg::ROT_LAT + fpisl_pkg::RECIP_LAT;
    localparam int ANGLE_PAD = 32 - ANGLE_BITS;

    // Reset offsets are 80000/254 and 60000/254 units in the coordinate format, rounded to nearest and
    // saturated to the 31-bit register range.
    localparam longint unsigned MASK31  = 64'h7FFF_FFFF;
    localparam longint unsigned FWD_RAW = ((64'd80000 << COORD_FRAC_BITS) + 64'd127) / 64'd254;
    localparam longint unsigned SIDE_RAW = ((64'd60000 << COORD_FRAC_BITS) + 64'd127) / 64'd254;
    localparam longint unsigned FWD_SAT  = (FWD_RAW > MASK31) ? MASK31 : FWD_RAW;
    localparam longint unsigned SIDE_SAT = (SIDE_RAW > MASK31) ? MASK31 : SIDE_RAW;
    localparam logic [30:0] FWD_RESET  = FWD_SAT[30:0];
    localparam logic [30:0] SIDE_RESET = SIDE_SAT[30:0];

    logic [30:0] offset_forward_reg;
    logic [30:0] offset_side_reg;

    // The whole chain moves together: it holds only while a finished result is refused.
    logic advance;

    logic [23:0] heading_ext;
    logic [31:0] angle;
    logic [30:0] r_sin;
    logic [30:0] r_cos;
    logic [30:0] sin_q;
    logic [30:0] cos_q;

    logic [PIPE_LAT-1:0] vld_reg;
    logic signed [31:0]  xd_reg [0:SINE_LAT-1];
    logic signed [31:0]  yd_reg [0:SINE_LAT-1];
    logic [1:0]          qd_reg [0:SINE_LAT-1];

    fpisl_pkg::point_t [3:0] points;
    logic [31:0] level [0:3];
    logic [3:0]  sat;

    logic        out_valid_reg;
    logic [31:0] fl_level_reg;
    logic [31:0] fr_level_reg;
    logic [31:0] rl_level_reg;
    logic [31:0] rr_level_reg;
    logic [3:0]  flags_reg;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = !advance;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_forward_reg <= FWD_RESET;
            offset_side_reg    <= SIDE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == fpisl_pkg::REG_OFFSET_FORWARD)
            begin
                offset_forward_reg <= cfg_data;
            end
            else if (cfg_index == fpisl_pkg::REG_OFFSET_SIDE)
            begin
                offset_side_reg <= cfg_data;
            end
        end
    end

    // The heading is scaled to a full 32-bit turn: the top two bits give the quadrant and the
    // rest the position within it. Cosine within a quadrant is the sine of its complement.
    assign heading_ext = {8'd0, heading};
    assign angle       = {heading_ext[ANGLE_BITS-1:0], {ANGLE_PAD{1'b0}}};
    assign r_sin       = {1'b0, angle[29:0]};
    assign r_cos       = fpisl_pkg::ONE_Q30 - r_sin;

    fpisl_qsine u_sine
    (
        .clk     (clk),
        .advance (advance),
        .angle   (r_sin),
        .sine    (sin_q)
    );

    fpisl_qsine u_cosine
    (
        .clk     (clk),
        .advance (advance),
        .angle   (r_cos),
        .sine    (cos_q)
    );

    // The pose and quadrant travel alongside the sine unit.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            xd_reg[0] <= pos_x;
            yd_reg[0] <= pos_y;
            qd_reg[0] <= angle[31:30];
            for (int i = 1; i < SINE_LAT; i++)
            begin
                xd_reg[i] <= xd_reg[i-1];
                yd_reg[i] <= yd_reg[i-1];
                qd_reg[i] <= qd_reg[i-1];
            end
        end
    end

    fpisl_rotate u_rotate
    (
        .clk      (clk),
        .advance  (advance),
        .sin_q    (sin_q),
        .cos_q    (cos_q),
        .quadrant (qd_reg[SINE_LAT-1]),
        .x        (xd_reg[SINE_LAT-1]),
        .y        (yd_reg[SINE_LAT-1]),
        .fwd      (offset_forward_reg),
        .side     (offset_side_reg),
        .points   (points)
    );

    for (genvar k = 0; k < 4; k++)
    begin : g_sensor
        fpisl_recip
        #(
            .COORD_FRAC_BITS (COORD_FRAC_BITS)
        )
        u_recip
        (
            .clk       (clk),
            .advance   (advance),
            .point     (points[k]),
            .level     (level[k]),
            .saturated (sat[k])
        );
    end

    // Valid bits follow the transactions through every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg       <= {vld_reg[PIPE_LAT-2:0], in_valid};
            out_valid_reg <= vld_reg[PIPE_LAT-1];
        end
    end

    // Output register: holds the result steady while the consumer stalls.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fl_level_reg <= level[0];
            fr_level_reg <= level[1];
            rl_level_reg <= level[2];
            rr_level_reg <= level[3];
            flags_reg    <= sat;
        end
    end

    assign out_valid         = out_valid_reg;
    assign front_left_level  = fl_level_reg;
    assign front_right_level = fr_level_reg;
    assign rear_left_level   = rl_level_reg;
    assign rear_right_level  = rr_level_reg;
    assign saturated_flags   = flags_reg;

`ifndef SYNTHESIS
    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("input taken while a result is refused");

    a_chain_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> vld_reg[0])
        else $error("accepted transaction did not enter the pipeline");

    a_sat_level: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated_flags[0]) |-> (front_left_level == 32'hFFFF_FFFF))
        else $error("saturated sensor without full-scale level");
`endif

endmodule
